>>> src/soke_pkg.sv
// Package for the steering offset estimator: payload structs, codes, fixed
// point constants and saturating helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package soke_pkg;

  localparam int unsigned Q_FRAC    = 32;
  localparam int unsigned MUL_CHUNK = 16;
  localparam int unsigned MUL_STEPS = 3;
  localparam int unsigned DVD_W     = 80;
  localparam int unsigned MAG_W     = 81;

  localparam logic signed [47:0] QMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] QMIN = 48'sh8000_0000_0000;
  localparam logic [MAG_W-1:0] QMAX_MAG = 81'h7FFF_FFFF_FFFF;
  localparam logic [MAG_W-1:0] QMIN_MAG = 81'h8000_0000_0000;

  localparam logic [1:0] CMD_REPORT = 2'd0;
  localparam logic [1:0] CMD_MOTION = 2'd1;
  localparam logic [1:0] CMD_LOAD   = 2'd2;

  localparam logic [1:0] STAT_UPDATED  = 2'd0;
  localparam logic [1:0] STAT_SLOW     = 2'd1;
  localparam logic [1:0] STAT_NO_STEER = 2'd2;
  localparam logic [1:0] STAT_STEER_HI = 2'd3;

  localparam logic [46:0] RST_WHEEL_BASE   = 47'd12884901888;
  localparam logic [46:0] RST_MIN_VELOCITY = 47'd4294967296;
  localparam logic [46:0] RST_MAX_STEER    = 47'd429496729;
  localparam logic [46:0] RST_PROC_NOISE   = 47'd4295;
  localparam logic [46:0] RST_MEAS_NOISE   = 47'd42950;
  localparam logic [46:0] RST_DEN_FLOOR    = 47'd4295;
  localparam logic [46:0] RST_COV_FLOOR    = 47'd43;
  localparam logic [31:0] RST_SPAN         = 32'd5000000;

  typedef enum logic [2:0] {
    REG_WHEEL_BASE   = 3'd0,
    REG_MIN_VELOCITY = 3'd1,
    REG_MAX_STEER    = 3'd2,
    REG_PROC_NOISE   = 3'd3,
    REG_MEAS_NOISE   = 3'd4,
    REG_DEN_FLOOR    = 3'd5,
    REG_COV_FLOOR    = 3'd6,
    REG_SPAN         = 3'd7
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RPT_RD,
    ST_RPT_CHK,
    ST_RPT_WR,
    ST_PRN_RD,
    ST_PRN_CHK,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_WIN,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_MEAN,
    ST_GATE,
    ST_PHI,
    ST_Y,
    ST_PHI2,
    ST_DEN,
    ST_GMUL,
    ST_GDIV,
    ST_RES,
    ST_OFS,
    ST_PM1,
    ST_PM2,
    ST_PDIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [47:0]        stamp_us;
    logic signed [47:0] steer_angle;
    logic signed [47:0] velocity;
    logic signed [47:0] yaw_rate;
    logic signed [47:0] load_offset;
    logic [46:0]        load_covariance;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [47:0] offset;
    logic [46:0]        covariance;
    logic signed [47:0] gain;
    logic signed [47:0] residual;
    logic signed [47:0] used_steering;
    logic signed [47:0] echoed_velocity;
    logic signed [47:0] echoed_yaw_rate;
  } out_item_t;

  function automatic logic [47:0] magn48(input logic signed [47:0] v);
    logic [47:0] u;
    u = v;
    return u[47] ? (~u + 48'd1) : u;
  endfunction

  function automatic logic signed [47:0] sat_mag(input logic [MAG_W-1:0] m, input logic neg);
    logic [47:0] low;
    low = m[47:0];
    if (neg) begin
      if (m > QMIN_MAG) return QMIN;
      return ~low + 48'd1;
    end
    if (m > QMAX_MAG) return QMAX;
    return low;
  endfunction

  function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
    logic [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) return s[48] ? QMIN : QMAX;
    return s[47:0];
  endfunction

  function automatic logic signed [47:0] sat_sub48(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
    logic [48:0] s;
    s = {a[47], a} - {b[47], b};
    if (s[48] != s[47]) return s[48] ? QMIN : QMAX;
    return s[47:0];
  endfunction

endpackage

`default_nettype wire

>>> src/soke_ring.sv
// Ring store of steering report stamps and angles, addressed relative to the
// ring head, with a registered read port. Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module soke_ring #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire                clk,
  input  wire  [AW-1:0]      head,
  input  wire                wr_en,
  input  wire  [AW-1:0]      wr_idx,
  input  wire  [47:0]        wr_stamp,
  input  wire  signed [47:0] wr_angle,
  input  wire  [AW-1:0]      rd_idx,
  output logic [47:0]        rd_stamp,
  output logic signed [47:0] rd_angle
);

  logic [47:0]        stamps [DEPTH];
  logic signed [47:0] angles [DEPTH];
  logic [AW:0]        wr_sum;
  logic [AW:0]        rd_sum;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;

  always_comb begin
    wr_sum = {1'b0, head} + {1'b0, wr_idx};
    rd_sum = {1'b0, head} + {1'b0, rd_idx};
    wr_addr = (wr_sum >= (AW + 1)'(DEPTH)) ? AW'(wr_sum - (AW + 1)'(DEPTH)) : wr_sum[AW-1:0];
    rd_addr = (rd_sum >= (AW + 1)'(DEPTH)) ? AW'(rd_sum - (AW + 1)'(DEPTH)) : rd_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamps[wr_addr] <= wr_stamp;
      angles[wr_addr] <= wr_angle;
    end
    rd_stamp <= stamps[rd_addr];
    rd_angle <= angles[rd_addr];
  end

endmodule

`default_nettype wire

>>> src/soke_mul.sv
// Shared Q15.32 multiplier: 48 by 16 bit partial products accumulated in turn,
// then rounding and saturation. Depends on soke_pkg.
`timescale 1ns / 1ps
`default_nettype none

module soke_mul (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  wire  signed [47:0] a,
  input  wire  signed [47:0] b,
  output logic               done,
  output logic signed [47:0] result
);

  localparam int unsigned CNT_W = $clog2(soke_pkg::MUL_STEPS);

  logic [47:0]      ma;
  logic [47:0]      mb;
  logic             neg;
  logic [95:0]      acc;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic             finishing;
  logic [63:0]      part;
  logic [96:0]      rnd;

  always_comb begin
    part = ma * mb[47 -: soke_pkg::MUL_CHUNK];
    rnd  = {1'b0, acc} + (97'd1 << (soke_pkg::Q_FRAC - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      finishing <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= finishing;
      if (start) begin
        ma      <= soke_pkg::magn48(a);
        mb      <= soke_pkg::magn48(b);
        neg     <= a[47] ^ b[47];
        acc     <= '0;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        acc <= (acc << soke_pkg::MUL_CHUNK) + 96'(part);
        mb  <= mb << soke_pkg::MUL_CHUNK;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(soke_pkg::MUL_STEPS - 1)) begin
          running   <= 1'b0;
          finishing <= 1'b1;
        end
      end
      if (finishing) begin
        finishing <= 1'b0;
        result    <= soke_pkg::sat_mag(81'(rnd[96:soke_pkg::Q_FRAC]), neg);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/soke_div.sv
// Shared restoring divider, one quotient bit per cycle over an 80 bit
// dividend, with optional round half up. Depends on soke_pkg.
`timescale 1ns / 1ps
`default_nettype none

module soke_div (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  input  wire  [soke_pkg::DVD_W-1:0]       dividend,
  input  wire  [47:0]                      divisor,
  input  wire                              round_en,
  output logic                             done,
  output logic [soke_pkg::MAG_W-1:0]       quotient
);

  localparam int unsigned CNT_W = $clog2(soke_pkg::DVD_W);

  logic [soke_pkg::DVD_W-1:0] dvd;
  logic [soke_pkg::DVD_W-1:0] q;
  logic [48:0]                r;
  logic [47:0]                d;
  logic [CNT_W-1:0]           cnt;
  logic                       rnd;
  logic                       running;
  logic                       finishing;
  logic [48:0]                rs;
  logic                       ge;
  logic                       up;

  always_comb begin
    rs = {r[47:0], dvd[soke_pkg::DVD_W-1]};
    ge = rs >= {1'b0, d};
    up = rnd && ({r[47:0], 1'b0} >= {1'b0, d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      finishing <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= finishing;
      if (start) begin
        dvd     <= dividend;
        d       <= divisor;
        rnd     <= round_en;
        r       <= '0;
        q       <= '0;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        r   <= ge ? (rs - {1'b0, d}) : rs;
        q   <= {q[soke_pkg::DVD_W-2:0], ge};
        dvd <= dvd << 1;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(soke_pkg::DVD_W - 1)) begin
          running   <= 1'b0;
          finishing <= 1'b1;
        end
      end
      if (finishing) begin
        finishing <= 1'b0;
        quotient  <= {1'b0, q} + soke_pkg::MAG_W'(up);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/steer_offset_kalman_estimator.sv
// Steering offset estimator top level: report ring, sequencer and Kalman update.
// Depends on soke_pkg, soke_ring, soke_mul and soke_div.
// A report checks the newest entry, drops a late stamp, writes the entry and prunes stale
// entries from the head; a load sets the estimate directly. A motion sample searches the
// ring, averages the reports around the match (one quotient for the mean) and runs the
// update (three quotients, eight products); one request at a time. Synchronous reset.
`timescale 1ns / 1ps
`default_nettype none

module steer_offset_kalman_estimator #(
  parameter int unsigned RING_DEPTH  = 64,
  parameter int unsigned HALF_WINDOW = 2
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  soke_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output soke_pkg::out_item_t out_data,
  input  wire                 cfg_we,
  input  wire  [2:0]          cfg_index,
  input  wire  [46:0]         cfg_data
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 2 * HALF_WINDOW + 2);
  localparam int unsigned NW = $clog2(2 * HALF_WINDOW + 2);
  localparam int unsigned SW = 48 + NW;

  soke_pkg::state_t   state;
  soke_pkg::state_t   state_next;
  soke_pkg::in_item_t item;

  logic [46:0] base_len;
  logic [46:0] speed_min;
  logic [46:0] steer_lim;
  logic [46:0] process_noise;
  logic [46:0] measurement_noise;
  logic [46:0] den_min;
  logic [46:0] cov_min;
  logic [31:0] buffer_span;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] upper;
  logic [CW-1:0] fin;
  logic [NW-1:0] n;
  logic          have;
  logic          launched;

  logic signed [SW-1:0] sum;
  logic signed [47:0]   offset_est;
  logic signed [47:0]   cov_est;
  logic signed [47:0]   mean;
  logic signed [47:0]   phi;
  logic signed [47:0]   phi2;
  logic signed [47:0]   y;
  logic signed [47:0]   prior;
  logic signed [47:0]   den;
  logic signed [47:0]   gain;
  logic signed [47:0]   resid;
  logic signed [47:0]   tmp;
  logic [1:0]           status;

  logic [47:0]        rd_stamp;
  logic signed [47:0] rd_angle;
  logic               wr_en;

  logic                         mul_start;
  logic                         mul_done;
  logic signed [47:0]           mul_a;
  logic signed [47:0]           mul_b;
  logic signed [47:0]           mul_res;
  logic                         div_start;
  logic                         div_done;
  logic [soke_pkg::DVD_W-1:0]   div_dvd;
  logic [47:0]                  div_dvs;
  logic                         div_round;
  logic [soke_pkg::MAG_W-1:0]   div_q;

  logic signed [47:0] qa;
  logic signed [47:0] qb;
  logic [47:0]        qa_mag;
  logic [47:0]        qb_mag;
  logic               q_zero;
  logic signed [47:0] q_zero_res;
  logic signed [47:0] qres;
  logic               step_done;

  logic [48:0]        age;
  logic               prune;
  logic               drop;
  logic [CW-1:0]      pivot;
  logic [CW-1:0]      win_start;
  logic [CW-1:0]      win_finish;
  logic [SW-1:0]      sum_mag;
  logic signed [47:0] den_cand;
  logic signed [47:0] pnew_cand;
  logic [CW-1:0]      idx_inc;
  logic [AW-1:0]      head_inc;

  soke_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk      (clk),
    .head     (head),
    .wr_en    (wr_en),
    .wr_idx   (count[AW-1:0]),
    .wr_stamp (item.stamp_us),
    .wr_angle (item.steer_angle),
    .rd_idx   (idx[AW-1:0]),
    .rd_stamp (rd_stamp),
    .rd_angle (rd_angle)
  );

  soke_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  soke_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .round_en (div_round),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    age       = {1'b0, item.stamp_us} - {1'b0, rd_stamp};
    prune     = (count != '0) && (age[48] || (age[47:0] > {16'd0, buffer_span}));
    drop      = item.stamp_us < rd_stamp;
    idx_inc   = idx + CW'(1);
    head_inc  = (head == AW'(RING_DEPTH - 1)) ? '0 : head + AW'(1);
    pivot     = (upper == '0) ? '0 : upper - CW'(1);
    win_start = (pivot > CW'(HALF_WINDOW)) ? pivot - CW'(HALF_WINDOW) : '0;
    win_finish = ((count - pivot) > CW'(HALF_WINDOW)) ? pivot + CW'(HALF_WINDOW + 1) : count;
    sum_mag   = sum[SW-1] ? (~sum + SW'(1)) : sum;
    qa        = (state == soke_pkg::ST_PHI) ? item.velocity : tmp;
    qb        = (state == soke_pkg::ST_PHI) ? $signed({1'b0, base_len}) : den;
    qa_mag    = soke_pkg::magn48(qa);
    qb_mag    = soke_pkg::magn48(qb);
    q_zero    = qb_mag == '0;
    q_zero_res = (qa_mag == '0) ? '0 : (qa[47] ? soke_pkg::QMIN : soke_pkg::QMAX);
    qres      = q_zero ? q_zero_res : soke_pkg::sat_mag(div_q, qa[47] ^ qb[47]);
    den_cand  = soke_pkg::sat_add48($signed({1'b0, measurement_noise}), mul_res);
    if (den_cand < $signed({1'b0, den_min})) begin
      den_cand = $signed({1'b0, den_min});
    end
    pnew_cand = soke_pkg::sat_sub48(prior, qres);
    if (pnew_cand < $signed({1'b0, cov_min})) begin
      pnew_cand = $signed({1'b0, cov_min});
    end
  end

  always_comb begin
    in_ready  = 1'b0;
    wr_en     = 1'b0;
    mul_start = 1'b0;
    mul_a     = phi;
    mul_b     = phi;
    div_start = 1'b0;
    div_dvd   = {qa_mag, 32'd0};
    div_dvs   = qb_mag;
    div_round = 1'b1;
    unique case (state)
      soke_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      soke_pkg::ST_RPT_WR: begin
        wr_en = 1'b1;
      end
      soke_pkg::ST_MEAN: begin
        div_dvd   = soke_pkg::DVD_W'(sum_mag) + soke_pkg::DVD_W'(n >> 1);
        div_dvs   = 48'(n);
        div_round = 1'b0;
        div_start = !launched;
      end
      soke_pkg::ST_PHI, soke_pkg::ST_GDIV, soke_pkg::ST_PDIV: begin
        div_start = !launched && !q_zero;
      end
      soke_pkg::ST_Y: begin
        mul_b     = mean;
        mul_start = !launched;
      end
      soke_pkg::ST_PHI2: begin
        mul_start = !launched;
      end
      soke_pkg::ST_DEN: begin
        mul_a     = phi2;
        mul_b     = prior;
        mul_start = !launched;
      end
      soke_pkg::ST_GMUL: begin
        mul_a     = prior;
        mul_start = !launched;
      end
      soke_pkg::ST_RES: begin
        mul_b     = offset_est;
        mul_start = !launched;
      end
      soke_pkg::ST_OFS: begin
        mul_a     = gain;
        mul_b     = resid;
        mul_start = !launched;
      end
      soke_pkg::ST_PM1: begin
        mul_a     = prior;
        mul_b     = phi2;
        mul_start = !launched;
      end
      soke_pkg::ST_PM2: begin
        mul_a     = tmp;
        mul_b     = prior;
        mul_start = !launched;
      end
      default: begin
      end
    endcase
    step_done = mul_done || div_done;
    if ((state == soke_pkg::ST_PHI || state == soke_pkg::ST_GDIV ||
         state == soke_pkg::ST_PDIV) && q_zero) begin
      step_done = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      soke_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_data.command)
            soke_pkg::CMD_REPORT:
              state_next = (count == '0) ? soke_pkg::ST_RPT_WR : soke_pkg::ST_RPT_RD;
            soke_pkg::CMD_MOTION:
              state_next = (count == '0) ? soke_pkg::ST_GATE : soke_pkg::ST_SRCH_RD;
            default: state_next = soke_pkg::ST_IDLE;
          endcase
        end
      end
      soke_pkg::ST_RPT_RD:  state_next = soke_pkg::ST_RPT_CHK;
      soke_pkg::ST_RPT_CHK: state_next = drop ? soke_pkg::ST_IDLE : soke_pkg::ST_RPT_WR;
      soke_pkg::ST_RPT_WR:  state_next = soke_pkg::ST_PRN_RD;
      soke_pkg::ST_PRN_RD:  state_next = soke_pkg::ST_PRN_CHK;
      soke_pkg::ST_PRN_CHK: state_next = prune ? soke_pkg::ST_PRN_RD : soke_pkg::ST_IDLE;
      soke_pkg::ST_SRCH_RD: state_next = soke_pkg::ST_SRCH_CHK;
      soke_pkg::ST_SRCH_CHK: begin
        if (rd_stamp > item.stamp_us || idx_inc == count) begin
          state_next = soke_pkg::ST_WIN;
        end else begin
          state_next = soke_pkg::ST_SRCH_RD;
        end
      end
      soke_pkg::ST_WIN:     state_next = soke_pkg::ST_SUM_RD;
      soke_pkg::ST_SUM_RD:  state_next = soke_pkg::ST_SUM_ACC;
      soke_pkg::ST_SUM_ACC: state_next = (idx_inc == fin) ? soke_pkg::ST_MEAN : soke_pkg::ST_SUM_RD;
      soke_pkg::ST_MEAN:    if (step_done) state_next = soke_pkg::ST_GATE;
      soke_pkg::ST_GATE: begin
        if (item.velocity < $signed({1'b0, speed_min}) || !have ||
            soke_pkg::magn48(mean) > {1'b0, steer_lim}) begin
          state_next = soke_pkg::ST_OUT;
        end else begin
          state_next = soke_pkg::ST_PHI;
        end
      end
      soke_pkg::ST_PHI:  if (step_done) state_next = soke_pkg::ST_Y;
      soke_pkg::ST_Y:    if (step_done) state_next = soke_pkg::ST_PHI2;
      soke_pkg::ST_PHI2: if (step_done) state_next = soke_pkg::ST_DEN;
      soke_pkg::ST_DEN:  if (step_done) state_next = soke_pkg::ST_GMUL;
      soke_pkg::ST_GMUL: if (step_done) state_next = soke_pkg::ST_GDIV;
      soke_pkg::ST_GDIV: if (step_done) state_next = soke_pkg::ST_RES;
      soke_pkg::ST_RES:  if (step_done) state_next = soke_pkg::ST_OFS;
      soke_pkg::ST_OFS:  if (step_done) state_next = soke_pkg::ST_PM1;
      soke_pkg::ST_PM1:  if (step_done) state_next = soke_pkg::ST_PM2;
      soke_pkg::ST_PM2:  if (step_done) state_next = soke_pkg::ST_PDIV;
      soke_pkg::ST_PDIV: if (step_done) state_next = soke_pkg::ST_OUT;
      soke_pkg::ST_OUT:  if (!out_valid || out_ready) state_next = soke_pkg::ST_IDLE;
      default:           state_next = soke_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= soke_pkg::ST_IDLE;
      launched          <= 1'b0;
      head              <= '0;
      count             <= '0;
      offset_est        <= '0;
      cov_est           <= '0;
      out_valid         <= 1'b0;
      base_len          <= soke_pkg::RST_WHEEL_BASE;
      speed_min         <= soke_pkg::RST_MIN_VELOCITY;
      steer_lim         <= soke_pkg::RST_MAX_STEER;
      process_noise     <= soke_pkg::RST_PROC_NOISE;
      measurement_noise <= soke_pkg::RST_MEAS_NOISE;
      den_min           <= soke_pkg::RST_DEN_FLOOR;
      cov_min           <= soke_pkg::RST_COV_FLOOR;
      buffer_span       <= soke_pkg::RST_SPAN;
    end else begin
      state <= state_next;
      if (mul_start || div_start) begin
        launched <= 1'b1;
      end else if (mul_done || div_done) begin
        launched <= 1'b0;
      end
      if (out_valid && out_ready && state != soke_pkg::ST_OUT) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (soke_pkg::cfg_reg_t'(cfg_index))
          soke_pkg::REG_WHEEL_BASE:   base_len          <= cfg_data;
          soke_pkg::REG_MIN_VELOCITY: speed_min         <= cfg_data;
          soke_pkg::REG_MAX_STEER:    steer_lim         <= cfg_data;
          soke_pkg::REG_PROC_NOISE:   process_noise     <= cfg_data;
          soke_pkg::REG_MEAS_NOISE:   measurement_noise <= cfg_data;
          soke_pkg::REG_DEN_FLOOR:    den_min           <= cfg_data;
          soke_pkg::REG_COV_FLOOR:    cov_min           <= cfg_data;
          soke_pkg::REG_SPAN:         buffer_span       <= cfg_data[31:0];
          default: begin
          end
        endcase
      end
      unique case (state)
        soke_pkg::ST_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            gain  <= '0;
            resid <= '0;
            mean  <= '0;
            have  <= count != '0;
            idx   <= (in_data.command == soke_pkg::CMD_REPORT) ? count - CW'(1) : '0;
            if (in_data.command == soke_pkg::CMD_LOAD) begin
              offset_est <= in_data.load_offset;
              cov_est    <= $signed({1'b0, in_data.load_covariance});
            end
          end
        end
        soke_pkg::ST_RPT_CHK: begin
          if (!drop && count >= CW'(RING_DEPTH)) begin
            head  <= head_inc;
            count <= CW'(RING_DEPTH - 1);
          end
        end
        soke_pkg::ST_RPT_WR: begin
          count <= count + CW'(1);
          idx   <= '0;
        end
        soke_pkg::ST_PRN_CHK: begin
          if (prune) begin
            head  <= head_inc;
            count <= count - CW'(1);
          end
        end
        soke_pkg::ST_SRCH_CHK: begin
          if (rd_stamp > item.stamp_us) begin
            upper <= idx;
          end else if (idx_inc == count) begin
            upper <= count;
          end else begin
            idx <= idx_inc;
          end
        end
        soke_pkg::ST_WIN: begin
          idx <= win_start;
          fin <= win_finish;
          n   <= NW'(win_finish - win_start);
          sum <= '0;
        end
        soke_pkg::ST_SUM_ACC: begin
          sum <= sum + {{(SW - 48){rd_angle[47]}}, rd_angle};
          idx <= idx_inc;
        end
        soke_pkg::ST_MEAN: begin
          if (step_done) mean <= soke_pkg::sat_mag(div_q, sum[SW-1]);
        end
        soke_pkg::ST_GATE: begin
          prior <= soke_pkg::sat_add48(cov_est, $signed({1'b0, process_noise}));
          if (item.velocity < $signed({1'b0, speed_min})) begin
            status <= soke_pkg::STAT_SLOW;
          end else if (!have) begin
            status <= soke_pkg::STAT_NO_STEER;
          end else if (soke_pkg::magn48(mean) > {1'b0, steer_lim}) begin
            status <= soke_pkg::STAT_STEER_HI;
          end else begin
            status <= soke_pkg::STAT_UPDATED;
          end
        end
        soke_pkg::ST_PHI:  if (step_done) phi <= qres;
        soke_pkg::ST_Y:    if (step_done) y <= soke_pkg::sat_sub48(item.yaw_rate, mul_res);
        soke_pkg::ST_PHI2: if (step_done) phi2 <= mul_res;
        soke_pkg::ST_DEN:  if (step_done) den <= den_cand;
        soke_pkg::ST_GMUL: if (step_done) tmp <= mul_res;
        soke_pkg::ST_GDIV: if (step_done) gain <= qres;
        soke_pkg::ST_RES:  if (step_done) resid <= soke_pkg::sat_sub48(y, mul_res);
        soke_pkg::ST_OFS:  if (step_done) offset_est <= soke_pkg::sat_add48(offset_est, mul_res);
        soke_pkg::ST_PM1:  if (step_done) tmp <= mul_res;
        soke_pkg::ST_PM2:  if (step_done) tmp <= mul_res;
        soke_pkg::ST_PDIV: if (step_done) cov_est <= pnew_cand;
        soke_pkg::ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid                <= 1'b1;
            out_data.status          <= status;
            out_data.offset          <= offset_est;
            out_data.covariance      <= cov_est[46:0];
            out_data.gain            <= gain;
            out_data.residual        <= resid;
            out_data.used_steering   <= mean;
            out_data.echoed_velocity <= item.velocity;
            out_data.echoed_yaw_rate <= item.yaw_rate;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for steer_offset_kalman_estimator: a queued request
// driver, a result monitor and a bit-exact Q15.32 Kalman predictor.
// Depends on soke_pkg and the estimator RTL; needs no files or arguments.
`timescale 1ns / 1ps

module testbench;

  localparam longint QHI = 64'sh7FFF_FFFF_FFFF;
  localparam longint QLO = -QHI - 1;
  localparam int DEPTH = 64;
  localparam int HALF = 2;
  localparam int SETTLE = 400;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  soke_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  soke_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [46:0] cfg_data = '0;

  steer_offset_kalman_estimator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  soke_pkg::in_item_t request_queue[$];
  soke_pkg::out_item_t pending_estimates[$];
  int errors = 0;
  int accepted = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  bit quiet = 1'b0;
  int send_gap = 0;
  int take_gap = 0;
  longint unsigned now_us = 0;

  // Predictor state and register copies.
  longint unsigned wb, minv, maxs, pnoise, mnoise, dfloor, cfloor, span;
  longint unsigned ring_stamp[DEPTH];
  longint ring_angle[DEPTH];
  int head = 0;
  int count = 0;
  longint est_offset = 0;
  longint est_cov = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat48(longint v);
    return v > QHI ? QHI : (v < QLO ? QLO : v);
  endfunction

  function automatic longint sat_mag(logic [127:0] m, bit neg);
    if (neg) return m > 128'(QHI) + 1 ? QLO : -longint'(m[63:0]);
    return m > 128'(QHI) ? QHI : longint'(m[63:0]);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    p = 128'(mag(a)) * 128'(mag(b)) + 128'h8000_0000;
    return sat_mag(p >> 32, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    logic [127:0] num, q, r, ub;
    longint unsigned ua;
    bit neg;
    ua = mag(a);
    ub = 128'(mag(b));
    neg = (a < 0) != (b < 0);
    if (ub == 0) return ua == 0 ? 0 : (a < 0 ? QLO : QHI);
    if (128'(ua >> 32) >= ub) return neg ? QLO : QHI;
    num = 128'(ua) << 32;
    q = num / ub;
    r = num % ub;
    if (r >= ub - r) q = q + 1;
    return sat_mag(q, neg);
  endfunction

  function automatic int slot(int i);
    return (head + i) % DEPTH;
  endfunction

  task automatic predict_request(soke_pkg::in_item_t it);
    longint vel, yaw, mean, gain, resid, phi, y, prior, phi2, den, pnew, sum;
    longint unsigned stamp, q;
    int upper, pivot, first, last, n;
    bit have;
    soke_pkg::out_item_t o;
    mean = 0; gain = 0; resid = 0; have = 0; sum = 0;
    stamp = 64'(it.stamp_us);
    accepted++;
    if (it.command == soke_pkg::CMD_REPORT) begin
      if (count > 0 && stamp < ring_stamp[slot(count - 1)]) return;
      if (count >= DEPTH) begin
        head = (head + 1) % DEPTH;
        count = DEPTH - 1;
      end
      ring_stamp[slot(count)] = stamp;
      ring_angle[slot(count)] = longint'($signed(it.steer_angle));
      count++;
      while (count > 0 && stamp - ring_stamp[head] > span) begin
        head = (head + 1) % DEPTH;
        count--;
      end
      return;
    end
    if (it.command == soke_pkg::CMD_LOAD) begin
      est_offset = longint'($signed(it.load_offset));
      est_cov = longint'(64'(it.load_covariance));
      return;
    end
    if (it.command != soke_pkg::CMD_MOTION) return;
    vel = longint'($signed(it.velocity));
    yaw = longint'($signed(it.yaw_rate));
    if (count > 0) begin
      upper = count;
      for (int i = 0; i < count; i++) begin
        if (ring_stamp[slot(i)] > stamp) begin
          upper = i;
          break;
        end
      end
      pivot = upper == 0 ? 0 : upper - 1;
      first = pivot > HALF ? pivot - HALF : 0;
      last = (count - pivot) > HALF ? pivot + HALF + 1 : count;
      n = last - first;
      for (int i = first; i < last; i++) sum += ring_angle[slot(i)];
      q = (mag(sum) + 64'(n / 2)) / 64'(n);
      mean = sat_mag(128'(q), sum < 0);
      have = 1;
    end
    if (vel < longint'(minv)) o.status = soke_pkg::STAT_SLOW;
    else if (!have) o.status = soke_pkg::STAT_NO_STEER;
    else if (mag(mean) > maxs) o.status = soke_pkg::STAT_STEER_HI;
    else begin
      o.status = soke_pkg::STAT_UPDATED;
      phi = fx_div(vel, longint'(wb));
      y = sat48(yaw - fx_mul(phi, mean));
      prior = sat48(est_cov + longint'(pnoise));
      phi2 = fx_mul(phi, phi);
      den = sat48(longint'(mnoise) + fx_mul(phi2, prior));
      if (den < longint'(dfloor)) den = longint'(dfloor);
      gain = fx_div(fx_mul(prior, phi), den);
      resid = sat48(y - fx_mul(phi, est_offset));
      est_offset = sat48(est_offset + fx_mul(gain, resid));
      pnew = sat48(prior - fx_div(fx_mul(fx_mul(prior, phi2), prior), den));
      if (pnew < longint'(cfloor)) pnew = longint'(cfloor);
      est_cov = pnew;
    end
    o.offset = est_offset[47:0];
    o.covariance = est_cov[46:0];
    o.gain = gain[47:0];
    o.residual = resid[47:0];
    o.used_steering = mean[47:0];
    o.echoed_velocity = vel[47:0];
    o.echoed_yaw_rate = yaw[47:0];
    pending_estimates.push_back(o);
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Request driver.
  always @(posedge clk) begin
    logic next_valid;
    soke_pkg::in_item_t next_data;
    next_valid = in_valid;
    next_data = in_data;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_data);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_queue.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 13);
          end else begin
            next_data = request_queue[0];
            request_queue.delete(0);
            next_valid = 1'b1;
          end
        end
      end
    end
    in_valid <= next_valid;
    in_data <= next_data;
  end

  // Result monitor.
  always @(posedge clk) begin
    soke_pkg::out_item_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_estimates.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data.status), 0);
        end else begin
          e = pending_estimates[0];
          pending_estimates.delete(0);
          status_seen[e.status]++;
          if (out_data.status != e.status)
            report_mismatch("status", 64'(out_data.status), 64'(e.status));
          if (out_data.offset != e.offset)
            report_mismatch("offset", 64'(out_data.offset), 64'(e.offset));
          if (out_data.covariance != e.covariance)
            report_mismatch("covariance", 64'(out_data.covariance), 64'(e.covariance));
          if (out_data.gain != e.gain)
            report_mismatch("gain", 64'(out_data.gain), 64'(e.gain));
          if (out_data.residual != e.residual)
            report_mismatch("residual", 64'(out_data.residual), 64'(e.residual));
          if (out_data.used_steering != e.used_steering)
            report_mismatch("used_steering", 64'(out_data.used_steering),
                            64'(e.used_steering));
          if (out_data.echoed_velocity != e.echoed_velocity)
            report_mismatch("echoed_velocity", 64'(out_data.echoed_velocity),
                            64'(e.echoed_velocity));
          if (out_data.echoed_yaw_rate != e.echoed_yaw_rate)
            report_mismatch("echoed_yaw_rate", 64'(out_data.echoed_yaw_rate),
                            64'(e.echoed_yaw_rate));
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        take_gap = $urandom_range(1, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(soke_pkg::cfg_reg_t idx, longint unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[46:0];
    case (idx)
      soke_pkg::REG_WHEEL_BASE:   wb = value & 64'h7FFF_FFFF_FFFF;
      soke_pkg::REG_MIN_VELOCITY: minv = value & 64'h7FFF_FFFF_FFFF;
      soke_pkg::REG_MAX_STEER:    maxs = value & 64'h7FFF_FFFF_FFFF;
      soke_pkg::REG_PROC_NOISE:   pnoise = value & 64'h7FFF_FFFF_FFFF;
      soke_pkg::REG_MEAS_NOISE:   mnoise = value & 64'h7FFF_FFFF_FFFF;
      soke_pkg::REG_DEN_FLOOR:    dfloor = value & 64'h7FFF_FFFF_FFFF;
      soke_pkg::REG_COV_FLOOR:    cfloor = value & 64'h7FFF_FFFF_FFFF;
      soke_pkg::REG_SPAN:         span = value & 64'hFFFF_FFFF;
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(longint unsigned w, longint unsigned v, longint unsigned s,
                         longint unsigned p, longint unsigned m, longint unsigned d,
                         longint unsigned c, longint unsigned sp);
    write_reg(soke_pkg::REG_WHEEL_BASE, w);
    write_reg(soke_pkg::REG_MIN_VELOCITY, v);
    write_reg(soke_pkg::REG_MAX_STEER, s);
    write_reg(soke_pkg::REG_PROC_NOISE, p);
    write_reg(soke_pkg::REG_MEAS_NOISE, m);
    write_reg(soke_pkg::REG_DEN_FLOOR, d);
    write_reg(soke_pkg::REG_COV_FLOOR, c);
    write_reg(soke_pkg::REG_SPAN, sp);
  endtask

  task automatic drain();
    while (request_queue.size() != 0 || in_valid || pending_estimates.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic soke_pkg::in_item_t mk(logic [1:0] cmd, longint unsigned st,
                                            longint steer, longint vel, longint yaw,
                                            longint lo, longint unsigned lc);
    soke_pkg::in_item_t it;
    it.command = cmd;
    it.stamp_us = st[47:0];
    it.steer_angle = steer[47:0];
    it.velocity = vel[47:0];
    it.yaw_rate = yaw[47:0];
    it.load_offset = lo[47:0];
    it.load_covariance = lc[46:0];
    return it;
  endfunction

  function automatic longint unsigned next_stamp();
    now_us += $urandom_range(0, 80000);
    return now_us;
  endfunction

  function automatic longint small_signed(int unsigned range);
    return longint'($urandom_range(0, 2 * range)) - longint'(range);
  endfunction

  function automatic soke_pkg::in_item_t make_request();
    soke_pkg::in_item_t it;
    logic [319:0] raw;
    int r;
    longint unsigned st;
    longint vel;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      for (int i = 0; i < 10; i++) raw[i*32 +: 32] = $urandom;
      it = raw[$bits(soke_pkg::in_item_t)-1:0];
      // Reports keep time moving forward so the ring stays usable.
      if (it.command == soke_pkg::CMD_REPORT) it.stamp_us = next_stamp();
      return it;
    end
    if (r < 55) begin
      if ($urandom_range(0, 9) == 0 && now_us > 200000)
        st = now_us - $urandom_range(1, 200000);
      else
        st = next_stamp();
      return mk(soke_pkg::CMD_REPORT, st, small_signed(515396075), 0, 0, 0, 0);
    end
    if (r < 95) begin
      st = now_us >= 300000 ? now_us - $urandom_range(0, 300000)
                            : longint'($urandom_range(0, 32'(now_us)));
      if ($urandom_range(0, 9) == 0) st = st + $urandom_range(0, 100000);
      vel = longint'($urandom_range(0, 32'h4000_0000)) * $urandom_range(0, 80);
      if ($urandom_range(0, 19) == 0) vel = -vel;
      return mk(soke_pkg::CMD_MOTION, st, 0, vel, small_signed(32'h7FFF_FFFF), 0, 0);
    end
    return mk(soke_pkg::CMD_LOAD, 0, 0, 0, 0, small_signed(32'h4000_0000),
              longint'($urandom_range(0, 32'h0100_0000)));
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) request_queue.push_back(make_request());
    drain();
  endtask

  initial begin
    wb = 64'(soke_pkg::RST_WHEEL_BASE);
    minv = 64'(soke_pkg::RST_MIN_VELOCITY);
    maxs = 64'(soke_pkg::RST_MAX_STEER);
    pnoise = 64'(soke_pkg::RST_PROC_NOISE);
    mnoise = 64'(soke_pkg::RST_MEAS_NOISE);
    dfloor = 64'(soke_pkg::RST_DEN_FLOOR);
    cfloor = 64'(soke_pkg::RST_COV_FLOOR);
    span = 64'(soke_pkg::RST_SPAN);
    for (int i = 0; i < DEPTH; i++) begin
      ring_stamp[i] = 0;
      ring_angle[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests on the reset settings.
    request_queue.push_back(mk(soke_pkg::CMD_MOTION, 100, 0, 64'sh2_0000_0000, 0, 0, 0));
    request_queue.push_back(mk(soke_pkg::CMD_MOTION, 100, 0, QLO, 0, 0, 0));
    request_queue.push_back(mk(soke_pkg::CMD_LOAD, 0, 0, 0, 0, QHI, 64'h7FFF_FFFF_FFFF));
    request_queue.push_back(mk(soke_pkg::CMD_LOAD, 0, 0, 0, 0, QLO, 0));
    request_queue.push_back(mk(CMD_SPARE, 64'hFFFF_FFFF_FFFF, -1, -1, -1, -1,
                               64'h7FFF_FFFF_FFFF));
    request_queue.push_back(mk(soke_pkg::CMD_REPORT, 1000, QHI, 0, 0, 0, 0));
    request_queue.push_back(mk(soke_pkg::CMD_REPORT, 500, 0, 0, 0, 0, 0));
    request_queue.push_back(mk(soke_pkg::CMD_MOTION, 1000, 0, 64'sh2_0000_0000, 0, 0, 0));
    request_queue.push_back(mk(soke_pkg::CMD_REPORT, 1000, QLO, 0, 0, 0, 0));
    request_queue.push_back(mk(soke_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0));
    for (int i = 1; i <= 5; i++)
      request_queue.push_back(mk(soke_pkg::CMD_REPORT, 20000 * i, small_signed(300000000),
                                 0, 0, 0, 0));
    request_queue.push_back(mk(soke_pkg::CMD_MOTION, 0, 0, 64'sh2_0000_0000,
                               64'sh1000_0000, 0, 0));
    request_queue.push_back(mk(soke_pkg::CMD_MOTION, 64'hFFFF_FFFF_FFFF, 0, QHI, QLO, 0, 0));
    request_queue.push_back(mk(soke_pkg::CMD_MOTION, 60000, 0, 64'sh1_0000_0000, QHI, 0, 0));
    request_queue.push_back(mk(soke_pkg::CMD_MOTION, 45000, 0, 64'sh5_0000_0000,
                               -64'sh800_0000, 0, 0));
    now_us = 100000;
    drain();
    random_phase(280);

    set_all(64'($urandom_range(1, 6)) << 32, 64'($urandom_range(0, 32'h8000_0000)),
            64'($urandom_range(32'h1000_0000, 32'h2000_0000)), $urandom_range(0, 100000),
            $urandom_range(0, 1000000), $urandom_range(0, 10000), $urandom_range(0, 1000),
            $urandom_range(200000, 8000000));
    random_phase(280);

    // Zero divisor and zero den floor; span keeps only the newest stamps.
    set_all(0, 0, 64'h7FFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF, 0, 0, 64'h7FFF_FFFF_FFFF, 0);
    random_phase(200);
    set_all(64'h7FFF_FFFF_FFFF, 0, 64'h7FFF_FFFF_FFFF, 0, 64'h7FFF_FFFF_FFFF,
            64'h7FFF_FFFF_FFFF, 0, 64'hFFFF_FFFF);
    random_phase(120);
    set_all(64'h7FFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF, 0, 1, 1, 1, 1, 1000000);
    random_phase(60);

    quiet = 1'b1;
    set_all(64'(soke_pkg::RST_WHEEL_BASE), 64'(soke_pkg::RST_MIN_VELOCITY),
            64'(soke_pkg::RST_MAX_STEER), 64'(soke_pkg::RST_PROC_NOISE),
            64'(soke_pkg::RST_MEAS_NOISE), 64'(soke_pkg::RST_DEN_FLOOR),
            64'(soke_pkg::RST_COV_FLOOR), 64'(soke_pkg::RST_SPAN));
    random_phase(260);

    $display("Covered %0d requests over six register settings, with random idling.",
             accepted);
    $display("Results by status: updated %0d, slow %0d, no steering %0d, too large %0d.",
             status_seen[soke_pkg::STAT_UPDATED], status_seen[soke_pkg::STAT_SLOW],
             status_seen[soke_pkg::STAT_NO_STEER], status_seen[soke_pkg::STAT_STEER_HI]);
    if (errors == 0) begin
      $display("[steer_offset_kalman_estimator] OK");
    end else begin
      $display("[steer_offset_kalman_estimator] ERROR");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("Timed out with %0d results still expected.", pending_estimates.size());
    $display("[steer_offset_kalman_estimator] ERROR");
    $finish;
  end

endmodule
